// ===== sv/tclg_pkg.sv =====
package tclg_pkg;

  // Field widths fixed by the item formats
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int CELL_W  = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  typedef logic [CELL_W-1:0] cell_t;

  // Cell codes
  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_A     = 2'd1;
  localparam cell_t CELL_B     = 2'd2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  // Reset value of both size registers
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

  // Neighbor counts of the life rule
  localparam logic [3:0] NBR_KEEP  = 4'd2;
  localparam logic [3:0] NBR_BIRTH = 4'd3;

endpackage

// ===== sv/tclg_in_if.sv =====
interface tclg_in_if;
  logic                          valid;
  logic                          ready;
  logic [tclg_pkg::CMD_W-1:0]    cmd;
  logic [tclg_pkg::COORD_W-1:0]  col;
  logic [tclg_pkg::COORD_W-1:0]  row;
  logic [tclg_pkg::CELL_W-1:0]   write_value;

  modport source (output valid, cmd, col, row, write_value, input ready);
  modport sink   (input valid, cmd, col, row, write_value, output ready);
endinterface

// ===== sv/tclg_out_if.sv =====
interface tclg_out_if;
  logic                          valid;
  logic                          ready;
  logic [tclg_pkg::CELL_W-1:0]   read_value;
  logic                          status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== sv/tclg_rule.sv =====
module tclg_rule (
  input  tclg_pkg::cell_t win_i [0:2][0:2],
  output tclg_pkg::cell_t next_o
);
  import tclg_pkg::*;

  logic [3:0] na;
  logic [3:0] nb;
  logic [3:0] total;
  cell_t      self_c;

  // Count colored neighbors around the window center
  always_comb begin
    na = 4'd0;
    nb = 4'd0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(c == 1 && r == 1)) begin
          if (win_i[c][r] == CELL_A) begin
            na = na + 4'd1;
          end else if (win_i[c][r] == CELL_B) begin
            nb = nb + 4'd1;
          end
        end
      end
    end
    total  = na + nb;
    self_c = win_i[1][1];
  end

  // Apply survival and birth with majority color
  always_comb begin
    if (self_c != CELL_EMPTY) begin
      next_o = (total == NBR_KEEP || total == NBR_BIRTH) ? self_c : CELL_EMPTY;
    end else if (total == NBR_BIRTH) begin
      next_o = (na > nb) ? CELL_A : CELL_B;
    end else begin
      next_o = CELL_EMPTY;
    end
  end

endmodule

// ===== sv/two_colour_life_generation.sv =====
// Channel   Dir  Payload                         Handshake
// in_ch     in   cmd, col, row, write_value      valid/ready
// out_ch    out  read_value, status              valid/ready
// cfg_*     in   cfg_index, cfg_wdata            cfg_we, no stall
//
// Write and read commands are taken only in idle; each result passes the command stage
// register and the result queue before it is offered; later commands need not wait for it.
// An advance holds the input until its sweep and drain are done: one cell per
// cycle through the grid memory's two read ports, plus one zero column per row.
// After reset a clearing pass writes all 2^(XW+YW) grid entries (4096 at default size)
// before the first transaction; configuration writes are taken always.
// A three-entry result queue keeps commands flowing while out_ch stalls, until it fills.
module two_colour_life_generation #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tclg_in_if.sink                            in_ch,
  tclg_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tclg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tclg_pkg::CFG_W-1:0]         cfg_wdata
);
  import tclg_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int GA = XW + YW;
  localparam int GRID_DEPTH = 1 << GA;
  localparam int LB_DEPTH = 1 << XW;
  localparam int QD = 3;
  localparam int QW = 2;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  typedef struct packed {
    cell_t read_value;
    logic  status;
  } res_t;

  // Configuration
  logic [CFG_W-1:0] gw_r;
  logic [CFG_W-1:0] gh_r;
  logic [CFG_W-1:0] act_w;
  logic [CFG_W-1:0] act_h;

  // Control
  logic [1:0]       state_r, state_nxt;
  logic [GA-1:0]    clr_r, clr_nxt;
  logic [CFG_W-1:0] fx_r, fx_nxt;
  logic [CFG_W-1:0] fy_r, fy_nxt;

  // Sweep pipeline
  logic             d_vld_r, d_vld_nxt;
  logic [CFG_W-1:0] d_x_r;
  logic [CFG_W-1:0] d_y_r;
  logic             d_zero_r;
  logic             d_up_r;
  logic             d_dn_r;
  logic             e_vld_r, e_vld_nxt;
  logic [CFG_W-1:0] e_x_r;
  logic [CFG_W-1:0] e_y_r;
  cell_t            win_r [0:2][0:2];
  cell_t            col_up, col_mid, col_dn;
  cell_t            new_cell;

  // Memories
  cell_t            grid_mem [0:GRID_DEPTH-1];
  cell_t            lb_mem [0:LB_DEPTH-1];
  cell_t            ga_q_r;
  cell_t            gb_q_r;
  cell_t            lb_q_r;
  logic             gw_en;
  logic [GA-1:0]    gw_addr;
  cell_t            gw_data;
  logic [GA-1:0]    ga_addr;
  logic [GA-1:0]    gb_addr;

  // Command stage and result queue
  logic             acc;
  logic             oob;
  logic             p_vld_r, p_vld_nxt;
  logic             p_rd_r, p_rd_nxt;
  logic             p_st_r, p_st_nxt;
  res_t             q_mem_r [0:QD-1];
  logic [QW-1:0]    hd_r, tl_r;
  logic [QW-1:0]    cnt_r;
  logic             pop;
  logic             drain_done;

  // Clamp the size registers to the usable range
  always_comb begin
    if (gw_r == '0) begin
      act_w = CFG_W'(1);
    end else if (int'(gw_r) > MAX_WIDTH) begin
      act_w = CFG_W'(MAX_WIDTH);
    end else begin
      act_w = gw_r;
    end
    if (gh_r == '0) begin
      act_h = CFG_W'(1);
    end else if (int'(gh_r) > MAX_HEIGHT) begin
      act_h = CFG_W'(MAX_HEIGHT);
    end else begin
      act_h = gh_r;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= CFG_SIZE_RESET;
      gh_r <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  gw_r <= cfg_wdata;
        CFG_GRID_HEIGHT: gh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept when idle and the queue has room for every result in flight
  assign in_ch.ready = (state_r == ST_IDLE) &&
                       ((3'({1'b0, cnt_r}) + 3'(p_vld_r)) <= 3'(QD - 1));
  assign acc = in_ch.valid && in_ch.ready;
  assign oob = (CFG_W'(in_ch.col) >= act_w) || (CFG_W'(in_ch.row) >= act_h);
  assign drain_done = (state_r == ST_DRAIN) && !d_vld_r && !e_vld_r;

  // Sequence clear, idle, sweep and drain
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    fx_nxt    = fx_r;
    fy_nxt    = fy_r;
    d_vld_nxt = 1'b0;
    p_vld_nxt = 1'b0;
    p_rd_nxt  = 1'b0;
    p_st_nxt  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + GA'(1);
        if (clr_r == {GA{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.cmd)
            CMD_WRITE: begin
              p_vld_nxt = 1'b1;
              p_st_nxt  = oob;
            end
            CMD_READ: begin
              p_vld_nxt = 1'b1;
              p_rd_nxt  = !oob;
              p_st_nxt  = oob;
            end
            CMD_ADVANCE: begin
              state_nxt = ST_SWEEP;
              fx_nxt    = '0;
              fy_nxt    = '0;
            end
            default: begin
              p_vld_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        d_vld_nxt = 1'b1;
        if (fx_r == act_w) begin
          fx_nxt = '0;
          fy_nxt = fy_r + CFG_W'(1);
          if (fy_r + CFG_W'(1) == act_h) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          fx_nxt = fx_r + CFG_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          p_vld_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign e_vld_nxt = d_vld_r && (d_x_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      fx_r    <= '0;
      fy_r    <= '0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fx_r    <= fx_nxt;
      fy_r    <= fy_nxt;
      d_vld_r <= d_vld_nxt;
      e_vld_r <= e_vld_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  // Carry sweep and command payload down the pipeline
  always_ff @(posedge clk) begin
    d_x_r    <= fx_r;
    d_y_r    <= fy_r;
    d_zero_r <= (fx_r == act_w);
    d_up_r   <= (fy_r != '0);
    d_dn_r   <= ((fy_r + CFG_W'(1)) < act_h);
    e_x_r    <= d_x_r - CFG_W'(1);
    e_y_r    <= d_y_r;
    p_rd_r   <= p_rd_nxt;
    p_st_r   <= p_st_nxt;
  end

  // Form the incoming column; rows and columns past the edge read empty
  assign col_up  = (d_up_r && !d_zero_r) ? lb_q_r : CELL_EMPTY;
  assign col_mid = !d_zero_r ? ga_q_r : CELL_EMPTY;
  assign col_dn  = (d_dn_r && !d_zero_r) ? gb_q_r : CELL_EMPTY;

  // Shift the 3x3 window; restart with empty columns at each row start
  always_ff @(posedge clk) begin
    if (d_vld_r) begin
      if (d_x_r == '0) begin
        for (int r = 0; r < 3; r++) begin
          win_r[0][r] <= CELL_EMPTY;
          win_r[1][r] <= CELL_EMPTY;
        end
      end else begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
      end
      win_r[2][0] <= col_up;
      win_r[2][1] <= col_mid;
      win_r[2][2] <= col_dn;
    end
  end

  tclg_rule u_rule (
    .win_i  (win_r),
    .next_o (new_cell)
  );

  // Select grid addresses and the write source
  always_comb begin
    if (state_r == ST_SWEEP) begin
      ga_addr = {YW'(fy_r), XW'(fx_r)};
    end else begin
      ga_addr = {YW'(in_ch.row), XW'(in_ch.col)};
    end
    gb_addr = {YW'(fy_r + CFG_W'(1)), XW'(fx_r)};
    if (e_vld_r) begin
      gw_en   = 1'b1;
      gw_addr = {YW'(e_y_r), XW'(e_x_r)};
      gw_data = new_cell;
    end else if (state_r == ST_CLEAR) begin
      gw_en   = 1'b1;
      gw_addr = clr_r;
      gw_data = CELL_EMPTY;
    end else begin
      gw_en   = acc && (in_ch.cmd == CMD_WRITE) && !oob;
      gw_addr = {YW'(in_ch.row), XW'(in_ch.col)};
      gw_data = (in_ch.write_value == CELL_A || in_ch.write_value == CELL_B) ?
                in_ch.write_value : CELL_EMPTY;
    end
  end

  // Grid memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (gw_en) begin
      grid_mem[gw_addr] <= gw_data;
    end
    ga_q_r <= grid_mem[ga_addr];
    gb_q_r <= grid_mem[gb_addr];
  end

  // Row buffer: read the row above ahead, then overwrite with the old current row
  always_ff @(posedge clk) begin
    if (d_vld_r && !d_zero_r) begin
      lb_mem[XW'(d_x_r)] <= col_mid;
    end
    lb_q_r <= lb_mem[XW'(fx_r)];
  end

  // Result queue
  assign pop = (cnt_r != '0) && out_ch.ready;
  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.read_value = q_mem_r[hd_r].read_value;
  assign out_ch.status     = q_mem_r[hd_r].status;

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      q_mem_r[tl_r].read_value <= p_rd_r ? ga_q_r : CELL_EMPTY;
      q_mem_r[tl_r].status     <= p_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r  <= '0;
      tl_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (p_vld_r) begin
        tl_r <= (tl_r == QW'(QD - 1)) ? '0 : tl_r + QW'(1);
      end
      if (pop) begin
        hd_r <= (hd_r == QW'(QD - 1)) ? '0 : hd_r + QW'(1);
      end
      if (p_vld_r && !pop) begin
        cnt_r <= cnt_r + QW'(1);
      end else if (!p_vld_r && pop) begin
        cnt_r <= cnt_r - QW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // Queue never takes a result while full unless one leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QW'(QD)) |-> (!p_vld_r || pop))
    else $error("result queue overflow");

  // Generation writes only land inside the active grid
  a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r |-> ((e_x_r < act_w) && (e_y_r < act_h)))
    else $error("generation write outside active grid");

  // Generation writes stay inside the sweep
  a_sweep_state: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("generation write outside sweep");

  // Fetch pointer stays inside the active grid plus one zero column
  a_fetch_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> ((fy_r < act_h) && (fx_r <= act_w)))
    else $error("fetch pointer out of range");

  // A finished sweep hands its result to the queue next cycle
  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> p_vld_r)
    else $error("advance result missing");
`endif

endmodule

// ===== tb/tb_two_colour_life_generation.sv =====
`timescale 1ns / 1ps

module tb_two_colour_life_generation;
  import tclg_pkg::*;

  localparam int GRID_MAX       = 64;
  localparam int TARGET_ITEMS   = 750;
  localparam int WATCHDOG_LIMIT = 25000;
  localparam int DRAIN_CYCLES   = 8;

  // Codes the package leaves unnamed: the spare command and the spare cell value
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'b11;
  localparam cell_t            CELL_UNUSED = 2'b11;

  typedef struct packed {
    cell_t read_value;
    logic  status;
  } reply_t;

  // Grid tracker: mirrors the cell grid and size registers, predicts each reply
  class life_grid_tracker;
    cell_t            cells [GRID_MAX][GRID_MAX];  // [row][col]
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    reply_t           pending_replies [$];
    int               errors;
    int               replies_seen;
    int               writes;
    int               reads;
    int               advances;

    function new();
      foreach (cells[r, c]) cells[r][c] = CELL_EMPTY;
      width_reg    = CFG_SIZE_RESET;
      height_reg   = CFG_SIZE_RESET;
      errors       = 0;
      replies_seen = 0;
      writes       = 0;
      reads        = 0;
      advances     = 0;
    endfunction

    function int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > GRID_MAX) return GRID_MAX;
      return int'(width_reg);
    endfunction

    function int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > GRID_MAX) return GRID_MAX;
      return int'(height_reg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_GRID_WIDTH:  width_reg = val;
        CFG_GRID_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // Compute one synchronous generation over the active area only
    function void next_generation();
      cell_t prior [GRID_MAX][GRID_MAX];
      int    aw;
      int    ah;
      int    na;
      int    nb;
      int    nx;
      int    ny;
      int    total;
      prior = cells;
      aw = active_width();
      ah = active_height();
      for (int y = 0; y < ah; y++) begin
        for (int x = 0; x < aw; x++) begin
          na = 0;
          nb = 0;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              ny = y + dy;
              nx = x + dx;
              // neighbors beyond the active edge count as empty
              if ((dy != 0 || dx != 0) && ny >= 0 && ny < ah && nx >= 0 && nx < aw) begin
                if (prior[ny][nx] == CELL_A) na++;
                else if (prior[ny][nx] == CELL_B) nb++;
              end
            end
          end
          total = na + nb;
          if (prior[y][x] != CELL_EMPTY) begin
            if (total != NBR_KEEP && total != NBR_BIRTH) cells[y][x] = CELL_EMPTY;
          end else if (total == NBR_BIRTH) begin
            cells[y][x] = (na > nb) ? CELL_A : CELL_B;
          end
        end
      end
    endfunction

    // Apply one accepted command and queue the reply it must produce
    function void note_command(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] col,
                               logic [COORD_W-1:0] row, cell_t wv);
      reply_t r;
      bit     outside;
      r.read_value = CELL_EMPTY;
      r.status     = 1'b0;
      outside = (col >= active_width()) || (row >= active_height());
      case (cmd)
        CMD_WRITE: begin
          writes++;
          if (outside) r.status = 1'b1;
          else cells[row][col] = (wv == CELL_A || wv == CELL_B) ? wv : CELL_EMPTY;
        end
        CMD_READ: begin
          reads++;
          if (outside) r.status = 1'b1;
          else r.read_value = cells[row][col];
        end
        CMD_ADVANCE: begin
          advances++;
          next_generation();
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_reply(cell_t rv, logic st);
      reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply %0d arrived with no command outstanding", replies_seen));
        return;
      end
      want = pending_replies.pop_front();
      if (rv !== want.read_value)
        report($sformatf("reply %0d read_value %0d, want %0d",
                         replies_seen, rv, want.read_value));
      if (st !== want.status)
        report($sformatf("reply %0d status %0b, want %0b", replies_seen, st, want.status));
    endtask

    task close_out();
      if (pending_replies.size() != 0)
        report($sformatf("%0d replies never arrived", pending_replies.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  tclg_in_if  in_ch ();
  tclg_out_if out_ch ();

  two_colour_life_generation u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  life_grid_tracker tracker = new();

  bit calm = 1'b0;
  int items_sent = 0;
  int size_settings = 0;
  int quiet_cycles = 0;
  int out_hold = 0;

  always #5 clk = ~clk;

  // Gap length: mostly none, some short, a few long; none at all in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cell_t pick_colour();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CELL_A;
    if (r < 80) return CELL_B;
    if (r < 92) return CELL_EMPTY;
    return CELL_UNUSED;
  endfunction

  // Observe every transaction at the rising edge, config first
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.set_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        tracker.note_command(in_ch.cmd, in_ch.col, in_ch.row, in_ch.write_value);
      if (out_ch.valid && out_ch.ready)
        tracker.check_reply(out_ch.read_value, out_ch.status);
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      out_hold = pick_gap();
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] col,
                          logic [COORD_W-1:0] row, cell_t wv);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.col         <= col;
    in_ch.row         <= row;
    in_ch.write_value <= wv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Drop valid and wait until every reply is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic resize(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    size_settings++;
  endtask

  // One random phase: pick a size, then seed, step and read back a window several times
  task automatic run_phase();
    int               pick;
    int               aw;
    int               ah;
    int               x0;
    int               x1;
    int               y0;
    int               y1;
    int               n;
    int               steps;
    bit               big;
    logic [CFG_W-1:0] wset;
    logic [CFG_W-1:0] hset;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      wset = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
      hset = CFG_W'($urandom_range(1, 10));
    end else if (pick == 1) begin
      wset = CFG_W'($urandom_range(1, 10));
      hset = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
    end else if (pick == 2) begin
      wset = CFG_W'($urandom_range(40, 127));
      hset = CFG_W'($urandom_range(40, 127));
    end else begin
      wset = CFG_W'($urandom_range(1, 12));
      hset = CFG_W'($urandom_range(1, 12));
    end
    resize(wset, hset);
    calm = ($urandom_range(0, 3) == 0);
    aw  = tracker.active_width();
    ah  = tracker.active_height();
    big = (aw * ah > 400);
    repeat ($urandom_range(2, 4)) begin
      // choose a window of at most 8x8 so patterns stay dense enough to evolve
      x0 = $urandom_range(0, aw - 1);
      y0 = $urandom_range(0, ah - 1);
      x1 = (x0 + 7 < aw) ? x0 + 7 : aw - 1;
      y1 = (y0 + 7 < ah) ? y0 + 7 : ah - 1;
      n  = (x1 - x0 + 1) * (y1 - y0 + 1);
      repeat ($urandom_range(1, (n > 24) ? 24 : n)) begin
        if ($urandom_range(0, 99) < 15)
          send_cmd(CMD_W'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 63)),
                   COORD_W'($urandom_range(0, 63)), CELL_W'($urandom_range(0, 3)));
        else
          send_cmd(CMD_WRITE, COORD_W'($urandom_range(x0, x1)),
                   COORD_W'($urandom_range(y0, y1)), pick_colour());
      end
      steps = big ? $urandom_range(0, 1) : $urandom_range(1, 3);
      repeat (steps)
        send_cmd(CMD_ADVANCE, COORD_W'($urandom_range(0, 63)),
                 COORD_W'($urandom_range(0, 63)), CELL_W'($urandom_range(0, 3)));
      repeat ((n > 16) ? 16 : n)
        send_cmd(CMD_READ, COORD_W'($urandom_range(x0, x1)),
                 COORD_W'($urandom_range(y0, y1)), CELL_W'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_GRID_WIDTH;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_WRITE;
    in_ch.col         = '0;
    in_ch.row         = '0;
    in_ch.write_value = CELL_EMPTY;
    out_ch.ready      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners, the spare write value and the spare command at full size
    send_cmd(CMD_WRITE, 0, 0, CELL_A);
    send_cmd(CMD_WRITE, 63, 63, CELL_B);
    send_cmd(CMD_WRITE, 63, 0, CELL_UNUSED);
    send_cmd(CMD_READ, 0, 0, CELL_EMPTY);
    send_cmd(CMD_READ, 63, 63, CELL_EMPTY);
    send_cmd(CMD_READ, 63, 0, CELL_EMPTY);
    send_cmd(CMD_READ, 5, 5, CELL_EMPTY);
    send_cmd(CMD_UNUSED, 63, 63, CELL_UNUSED);

    // Mixed blinker: births take the majority colour, isolated corners die
    send_cmd(CMD_WRITE, 10, 9, CELL_A);
    send_cmd(CMD_WRITE, 10, 10, CELL_A);
    send_cmd(CMD_WRITE, 10, 11, CELL_B);
    send_cmd(CMD_ADVANCE, 0, 0, CELL_EMPTY);
    send_cmd(CMD_READ, 9, 10, CELL_EMPTY);
    send_cmd(CMD_READ, 11, 10, CELL_EMPTY);
    send_cmd(CMD_READ, 10, 9, CELL_EMPTY);
    send_cmd(CMD_READ, 0, 0, CELL_EMPTY);

    // Zero width and over-range height clamp; out-of-bounds accesses are refused
    resize(7'd0, 7'd127);
    send_cmd(CMD_WRITE, 1, 5, CELL_B);
    send_cmd(CMD_READ, 0, 63, CELL_EMPTY);
    send_cmd(CMD_READ, 1, 0, CELL_EMPTY);

    // Shrink below the live cells, step, then grow back and find them untouched
    resize(7'd3, 7'd3);
    send_cmd(CMD_ADVANCE, 63, 63, CELL_UNUSED);
    send_cmd(CMD_READ, 3, 0, CELL_EMPTY);
    send_cmd(CMD_WRITE, 0, 3, CELL_A);
    resize(7'd64, 7'd64);
    send_cmd(CMD_READ, 10, 10, CELL_EMPTY);
    send_cmd(CMD_READ, 9, 10, CELL_EMPTY);

    while (items_sent < TARGET_ITEMS) run_phase();

    drain();
    tracker.close_out();
    $display("Checked %0d replies to %0d commands: %0d writes, %0d reads, %0d generations",
             tracker.replies_seen, items_sent, tracker.writes, tracker.reads,
             tracker.advances);
    $display("Grid sizes applied: %0d, with zero and over-range register values among them",
             size_settings);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== two_colour_life_generation.f =====
sv/tclg_pkg.sv
sv/tclg_in_if.sv
sv/tclg_out_if.sv
sv/tclg_rule.sv
sv/two_colour_life_generation.sv
tb/tb_two_colour_life_generation.sv
